// ===== rtl/three_point_angle_defines.svh =====
// Assertion macros shared by the angle block.
`ifndef THREE_POINT_ANGLE_DEFINES_SVH
`define THREE_POINT_ANGLE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define TPA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset.
`define TPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tpa_pkg.sv =====
package tpa_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int KEEP_BITS = 15;
    localparam int CORDIC_STEPS = 18;
    localparam int ANG_W = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;
    // Scaled legs hold 16-bit signed values; products are 31 bits.
    localparam int SC_W = 16;
    localparam int CR_W = 33;
    localparam int CSQ_W = 64;
    localparam int CX_W = 44;
    localparam int Z_W = 26;
    localparam logic [Z_W-1:0] ANG_90 = Z_W'(90 * 65536);
    localparam logic [Z_W-1:0] ANG_180 = Z_W'(180 * 65536);
    localparam logic [ANG_W-1:0] ANG_MAX = 16'd46080;

    // Scaled leg handed from the front part to the back part.
    typedef struct packed {
        logic              degenerate;
        logic signed [SC_W-1:0] ax;
        logic signed [SC_W-1:0] ay;
        logic signed [SC_W-1:0] az;
        logic signed [SC_W-1:0] bx;
        logic signed [SC_W-1:0] by;
        logic signed [SC_W-1:0] bz;
    } legs_t;

    function automatic logic [Z_W-1:0] atan_entry(input int i);
        logic [Z_W-1:0] t;
        case (i)
            0: t = 26'd2949120;
            1: t = 26'd1740967;
            2: t = 26'd919879;
            3: t = 26'd466945;
            4: t = 26'd234379;
            5: t = 26'd117304;
            6: t = 26'd58666;
            7: t = 26'd29335;
            8: t = 26'd14668;
            9: t = 26'd7334;
            10: t = 26'd3667;
            11: t = 26'd1833;
            12: t = 26'd917;
            13: t = 26'd458;
            14: t = 26'd229;
            15: t = 26'd115;
            16: t = 26'd57;
            17: t = 26'd29;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/tpa_if.sv =====
interface tpa_in_if #(parameter int CW = 32);
    logic valid;
    logic ready;
    logic signed [CW-1:0] first_x, first_y, first_z;
    logic signed [CW-1:0] vertex_x, vertex_y, vertex_z;
    logic signed [CW-1:0] second_x, second_y, second_z;
    modport source (output valid, first_x, first_y, first_z, vertex_x, vertex_y, vertex_z,
        second_x, second_y, second_z, input ready);
    modport sink (input valid, first_x, first_y, first_z, vertex_x, vertex_y, vertex_z,
        second_x, second_y, second_z, output ready);
endinterface

interface tpa_out_if;
    logic valid;
    logic ready;
    logic [15:0] angle_deg;
    logic degenerate;
    modport source (output valid, angle_deg, degenerate, input ready);
    modport sink (input valid, angle_deg, degenerate, output ready);
endinterface

interface tpa_cfg_if;
    logic valid;
    logic ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== rtl/tpa_front.sv =====
// Front part: leg vectors, short leg test and per-leg scaling to 15 bits.
// Three stages; advances while the downstream queue has a free entry or is read.
module tpa_front #(
    parameter int COORD_WIDTH = tpa_pkg::COORD_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [COORD_WIDTH-1:0] fx, fy, fz, vx, vy, vz, sx, sy, sz,
    input  logic [15:0]     min_len,
    output logic            out_valid,
    output tpa_pkg::legs_t  out_legs
);
    import tpa_pkg::*;

    localparam int MW = COORD_WIDTH + 1;
    localparam int BLW = $clog2(MW + 1);

    // Stage 1 registers: magnitudes and signs.
    logic [MW-1:0] mag_reg [6];
    logic          neg_reg [6];
    logic          v1_reg;
    // Stage 2 registers: squared sums and shift amounts.
    logic [33:0]   sq_reg [2];
    logic          small_reg [2];
    logic [BLW-1:0] sh_reg [2];
    logic [MW-1:0] mag2_reg [6];
    logic          neg2_reg [6];
    logic [31:0]   lim_reg;
    logic          v2_reg;
    logic          v3_reg;
    legs_t         legs_reg;

    logic [COORD_WIDTH-1:0] ends [6];
    logic [COORD_WIDTH-1:0] vtx [3];
    logic [33:0]   sq_next [2];
    logic          small_next [2];
    logic [BLW-1:0] sh_next [2];
    logic signed [SC_W-1:0] sc_next [6];
    logic          deg_next;

    assign ends = '{fx, fy, fz, sx, sy, sz};
    assign vtx = '{vx, vy, vz};

    // Leg differences on biased coordinates, exact as sign and magnitude.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 6; k++)
            begin
                logic [MW-1:0] e, v;
                e = {1'b0, ends[k] ^ (COORD_WIDTH'(1) << (COORD_WIDTH - 1))};
                v = {1'b0, vtx[k % 3] ^ (COORD_WIDTH'(1) << (COORD_WIDTH - 1))};
                neg_reg[k] <= e < v;
                mag_reg[k] <= (e >= v) ? e - v : v - e;
            end
        end
    end

    // Squared length per leg and bit length of the largest magnitude.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic [MW-1:0] mx;
            logic fits;
            sq_next[l] = '0;
            fits = 1'b1;
            mx = '0;
            sh_next[l] = '0;
            for (int k = 0; k < 3; k++)
            begin
                if (mag_reg[3*l+k] > MW'(16'hFFFF))
                    fits = 1'b0;
                sq_next[l] = sq_next[l] + 34'(mag_reg[3*l+k][15:0] * mag_reg[3*l+k][15:0]);
                if (mag_reg[3*l+k] > mx)
                    mx = mag_reg[3*l+k];
            end
            small_next[l] = fits;
            for (int b = 0; b < MW; b++)
            begin
                if (mx[b] && b + 1 > KEEP_BITS)
                    sh_next[l] = BLW'(b + 1 - KEEP_BITS);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg <= sq_next;
            small_reg <= small_next;
            sh_reg <= sh_next;
            mag2_reg <= mag_reg;
            neg2_reg <= neg_reg;
            lim_reg <= min_len * min_len;
        end
    end

    // Apply the shift and sign; decide the short leg flag.
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            logic [MW-1:0] s;
            s = mag2_reg[k] >> sh_reg[k / 3];
            sc_next[k] = neg2_reg[k] ? -SC_W'(s) : SC_W'(s);
        end
        deg_next = (small_reg[0] && sq_reg[0] <= 34'(lim_reg))
            || (small_reg[1] && sq_reg[1] <= 34'(lim_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            legs_reg <= '{deg_next, sc_next[0], sc_next[1], sc_next[2],
                sc_next[3], sc_next[4], sc_next[5]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_legs = legs_reg;
endmodule

// ===== rtl/tpa_queue.sv =====
// Short queue between the front and back parts.
module tpa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  tpa_pkg::legs_t wr_data,
    input  logic           rd_en,
    output tpa_pkg::legs_t rd_data,
    output logic           not_empty,
    output logic [tpa_pkg::QUEUE_AW:0] count
);
    import tpa_pkg::*;

    legs_t mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wp_reg, rp_reg;
    logic [QUEUE_AW:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QUEUE_AW+1)'(wr_en) - (QUEUE_AW+1)'(rd_en);
        end
    end

    assign rd_data = mem_reg[rp_reg];
    assign not_empty = cnt_reg != '0;
    assign count = cnt_reg;
endmodule

// ===== rtl/tpa_back.sv =====
// Back part: dot and cross products, square root, CORDIC and output rounding.
// A fully pipelined datapath that advances when its output stage is free.
module tpa_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  tpa_pkg::legs_t in_legs,
    output logic           out_valid,
    output logic [15:0]    angle,
    output logic           degenerate
);
    import tpa_pkg::*;

    localparam int SQ_STEPS = 32;
    localparam int NST = 3 + SQ_STEPS + CORDIC_STEPS + 1;

    // Stage A: products.
    logic signed [31:0] p_reg [9];
    logic               deg_a_reg;
    // Stage B: dot and cross components.
    logic signed [CR_W:0] dot_b_reg;
    logic [CR_W-1:0]    cm_b_reg [3];
    logic               deg_b_reg;
    // Stage C: squared cross magnitude.
    logic [CSQ_W-1:0]   csq_c_reg;
    logic signed [CR_W:0] dot_c_reg;
    logic               deg_c_reg;
    // Square root pipeline, one result bit per stage.
    logic [CSQ_W-1:0]   sq_n_reg [SQ_STEPS+1];
    logic [CSQ_W-1:0]   sq_r_reg [SQ_STEPS+1];
    logic signed [CR_W:0] sq_d_reg [SQ_STEPS+1];
    logic               sq_g_reg [SQ_STEPS+1];
    // CORDIC pipeline.
    logic signed [CX_W-1:0] cx_reg [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] cy_reg [CORDIC_STEPS+1];
    logic signed [Z_W:0]    z_reg [CORDIC_STEPS+1];
    logic                   neg_reg [CORDIC_STEPS+1];
    logic                   zero_reg [CORDIC_STEPS+1];
    logic                   dg_reg [CORDIC_STEPS+1];
    logic [15:0]            ang_reg;
    logic                   deg_o_reg;
    logic [NST-1:0]         vld_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg[0] <= in_legs.ax * in_legs.bx;
            p_reg[1] <= in_legs.ay * in_legs.by;
            p_reg[2] <= in_legs.az * in_legs.bz;
            p_reg[3] <= in_legs.ay * in_legs.bz;
            p_reg[4] <= in_legs.az * in_legs.by;
            p_reg[5] <= in_legs.az * in_legs.bx;
            p_reg[6] <= in_legs.ax * in_legs.bz;
            p_reg[7] <= in_legs.ax * in_legs.by;
            p_reg[8] <= in_legs.ay * in_legs.bx;
            deg_a_reg <= in_legs.degenerate;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic signed [CR_W:0] c0, c1, c2;
            c0 = (CR_W+1)'(p_reg[3]) - (CR_W+1)'(p_reg[4]);
            c1 = (CR_W+1)'(p_reg[5]) - (CR_W+1)'(p_reg[6]);
            c2 = (CR_W+1)'(p_reg[7]) - (CR_W+1)'(p_reg[8]);
            dot_b_reg <= (CR_W+1)'(p_reg[0]) + (CR_W+1)'(p_reg[1]) + (CR_W+1)'(p_reg[2]);
            cm_b_reg[0] <= CR_W'(c0 < 0 ? -c0 : c0);
            cm_b_reg[1] <= CR_W'(c1 < 0 ? -c1 : c1);
            cm_b_reg[2] <= CR_W'(c2 < 0 ? -c2 : c2);
            deg_b_reg <= deg_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            csq_c_reg <= CSQ_W'(cm_b_reg[0][31:0] * cm_b_reg[0][31:0])
                + CSQ_W'(cm_b_reg[1][31:0] * cm_b_reg[1][31:0])
                + CSQ_W'(cm_b_reg[2][31:0] * cm_b_reg[2][31:0]);
            dot_c_reg <= dot_b_reg;
            deg_c_reg <= deg_b_reg;
        end
    end

    // Restoring square root, one result bit per stage, high bit first.
    always_comb
    begin
        sq_n_reg[0] = csq_c_reg;
        sq_r_reg[0] = '0;
        sq_d_reg[0] = dot_c_reg;
        sq_g_reg[0] = deg_c_reg;
    end

    for (genvar s = 0; s < SQ_STEPS; s++)
    begin : g_sqrt
        localparam logic [CSQ_W-1:0] BIT = CSQ_W'(1) << (62 - 2 * s);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (sq_n_reg[s] >= sq_r_reg[s] + BIT)
                begin
                    sq_n_reg[s+1] <= sq_n_reg[s] - (sq_r_reg[s] + BIT);
                    sq_r_reg[s+1] <= (sq_r_reg[s] >> 1) + BIT;
                end
                else
                begin
                    sq_n_reg[s+1] <= sq_n_reg[s];
                    sq_r_reg[s+1] <= sq_r_reg[s] >> 1;
                end
                sq_d_reg[s+1] <= sq_d_reg[s];
                sq_g_reg[s+1] <= sq_g_reg[s];
            end
        end
    end

    // CORDIC input from the root and the dot magnitude.
    always_comb
    begin
        logic signed [CR_W:0] dm;
        dm = sq_d_reg[SQ_STEPS] < 0 ? -sq_d_reg[SQ_STEPS] : sq_d_reg[SQ_STEPS];
        cx_reg[0] = CX_W'(dm) <<< 8;
        cy_reg[0] = CX_W'(sq_r_reg[SQ_STEPS][32:0]) <<< 8;
        z_reg[0] = '0;
        neg_reg[0] = sq_d_reg[SQ_STEPS] < 0;
        zero_reg[0] = dm == 0 && sq_r_reg[SQ_STEPS] == 0;
        dg_reg[0] = sq_g_reg[SQ_STEPS];
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (cy_reg[i] > 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + (Z_W+1)'(atan_entry(i));
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - (Z_W+1)'(atan_entry(i));
                end
                neg_reg[i+1] <= neg_reg[i];
                zero_reg[i+1] <= zero_reg[i];
                dg_reg[i+1] <= dg_reg[i];
            end
        end
    end

    // Clamp, quadrant fold, rounding and saturation.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic signed [Z_W:0] z;
            logic [Z_W-1:0] a;
            logic [Z_W-8:0] r;
            z = z_reg[CORDIC_STEPS];
            if (z < 0)
                z = '0;
            if (z > $signed({1'b0, ANG_90}))
                z = $signed({1'b0, ANG_90});
            a = neg_reg[CORDIC_STEPS] ? ANG_180 - Z_W'(z) : Z_W'(z);
            if (zero_reg[CORDIC_STEPS])
                a = '0;
            r = (Z_W-7)'((a + Z_W'(128)) >> 8);
            ang_reg <= dg_reg[CORDIC_STEPS] ? '0
                : (r > (Z_W-7)'(ANG_MAX) ? ANG_MAX : 16'(r));
            deg_o_reg <= dg_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    assign out_valid = vld_reg[NST-1];
    assign angle = ang_reg;
    assign degenerate = deg_o_reg;
endmodule

// ===== rtl/three_point_angle.sv =====
// Angle at a vertex between two legs in 3D, in 1/256 degree.
// Channels: in_ch takes a transaction of three Q16.16 points (first leg end,
// vertex, second leg end); out_ch delivers angle_deg and the degenerate flag;
// cfg_ch writes min_leg_length and is always ready; write it only while the
// block is idle, which the block itself does not enforce. Throughput: one
// transaction per cycle while out_ch is not stalled. Path: front stages, the
// queue, then the back: products, 32-step square root, 18 CORDIC steps, round.
// The back pipeline moves only while its output register is free, so a
// stalled receiver holds results in place; the front keeps accepting until
// the queue between the two parts fills, then drops in_ch.ready.
// Reset clears all valid flags, the queue pointers and the register to 0.
`include "three_point_angle_defines.svh"
module three_point_angle #(
    parameter int COORD_WIDTH = tpa_pkg::COORD_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    tpa_in_if.sink   in_ch,
    tpa_out_if.source out_ch,
    tpa_cfg_if.sink  cfg_ch
);
    import tpa_pkg::*;

    logic [15:0] min_len_reg;
    logic f_adv, f_valid, b_adv, q_rd, q_ne;
    legs_t f_legs, q_data;
    logic [QUEUE_AW:0] q_cnt;

    // Register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_len_reg <= '0;
        else if (cfg_ch.valid)
            min_len_reg <= cfg_ch.data;
    end
    assign cfg_ch.ready = 1'b1;

    // Front advances while the queue has a free entry or is read this cycle.
    assign f_adv = q_cnt < (QUEUE_AW+1)'(QUEUE_DEPTH) || q_rd;
    assign in_ch.ready = f_adv;

    tpa_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .adv(f_adv), .in_valid(in_ch.valid),
        .fx(in_ch.first_x), .fy(in_ch.first_y), .fz(in_ch.first_z),
        .vx(in_ch.vertex_x), .vy(in_ch.vertex_y), .vz(in_ch.vertex_z),
        .sx(in_ch.second_x), .sy(in_ch.second_y), .sz(in_ch.second_z),
        .min_len(min_len_reg), .out_valid(f_valid), .out_legs(f_legs));

    tpa_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(f_valid && f_adv), .wr_data(f_legs),
        .rd_en(q_rd), .rd_data(q_data), .not_empty(q_ne), .count(q_cnt));

    // Back advances unless a finished result is stalled at the output.
    assign b_adv = !out_ch.valid || out_ch.ready;
    assign q_rd = b_adv && q_ne;

    tpa_back u_back (
        .clk(clk), .rst_n(rst_n), .adv(b_adv), .in_valid(q_rd), .in_legs(q_data),
        .out_valid(out_ch.valid), .angle(out_ch.angle_deg),
        .degenerate(out_ch.degenerate));

    `TPA_ASSERT_IMPL(a_queue_bound, 1'b1, q_cnt <= (QUEUE_AW+1)'(QUEUE_DEPTH),
        "queue count over depth")
    `TPA_ASSERT_IMPL(a_no_overflow, f_valid && f_adv,
        q_cnt < (QUEUE_AW+1)'(QUEUE_DEPTH) || q_rd, "queue overflow")
    `TPA_ASSERT_IMPL(a_deg_zero, out_ch.valid && out_ch.degenerate,
        out_ch.angle_deg == '0, "degenerate result with nonzero angle")
    `TPA_ASSERT_NEXT(a_hold, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(out_ch.angle_deg), "stalled result changed")
endmodule
